// File: src/ms_pkg.sv
// ----------------------------------------------------------------------------
// ms_pkg
// Shared types and codes for the merge sorter.
// ----------------------------------------------------------------------------
package ms_pkg;

    localparam int unsigned KindW   = 2;
    localparam int unsigned StatusW = 2;
    localparam int unsigned TotalW  = 11;
    localparam int unsigned DataW   = 32;

    localparam logic [KindW-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KindW-1:0] KIND_SORT  = 2'd1;
    localparam logic [KindW-1:0] KIND_READ  = 2'd2;
    localparam logic [KindW-1:0] KIND_SPARE = 2'd3;

    localparam logic [StatusW-1:0] ST_OK   = 2'd0;
    localparam logic [StatusW-1:0] ST_FULL = 2'd1;
    localparam logic [StatusW-1:0] ST_PAST = 2'd2;

    typedef struct packed {
        logic        [KindW-1:0] kind;
        logic signed [DataW-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [DataW-1:0]   value_res;
        logic        [StatusW-1:0] status;
        logic                      last;
        logic        [TotalW-1:0]  element_total;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;       // write incoming value at count
        logic clear;      // start a new set
        logic read_req;   // read store at read pointer
        logic nop_item;   // zero the result fields
        logic sort_start; // set width to one, begin first pass
        logic run_init;   // set up run at lo
        logic merge_step; // issue one store read for merge
        logic copy_step;  // copy scratch back to store
        logic pass_next;  // double width
        logic sort_done;  // clear read pointer
        logic out_load;   // latch result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic run_done;   // current run fully merged
        logic pass_done;  // lo passed count
        logic sort_over;  // width reached count
        logic copy_done;  // copy finished
    } t_stat;

endpackage

// File: src/merge_sorter.sv
// ----------------------------------------------------------------------------
// merge_sorter
// Loads, sorts ascending (stable bottom-up merge) and reads back signed words.
// ----------------------------------------------------------------------------
// Load, read and unused-kind transactions are accepted in S_IDLE, then the
// result is formed in S_RDW and held in the output register until taken; the
// next transaction is accepted in the cycle that result is taken. A sort makes
// ceil(log2 N) passes over N held values; each pass merges its runs into
// scratch, then copies scratch back to the store.
module merge_sorter #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ms_pkg::t_in_item  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ms_pkg::t_out_item o_out_data
);
    import ms_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ms_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .i_kind(i_in_data.kind), .o_in_ready,
        .o_out_valid, .i_out_ready, .i_stat(w_stat), .o_cmd(w_cmd)
    );

    ms_data #(.DEPTH(DEPTH)) u_data (
        .i_clk, .i_rst_n, .i_item(i_in_data), .i_cmd(w_cmd), .o_stat(w_stat),
        .o_item(o_out_data)
    );

endmodule

// File: src/ms_ctrl.sv
// ----------------------------------------------------------------------------
// ms_ctrl
// Sequencer for transactions and the merge sort passes.
// ----------------------------------------------------------------------------
module ms_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [ms_pkg::KindW-1:0] i_kind,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    input  ms_pkg::t_stat          i_stat,
    output ms_pkg::t_cmd           o_cmd
);
    import ms_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RDW   = 7'b0000010,
        S_INIT  = 7'b0000100,
        S_MERGE = 7'b0001000,
        S_COPY  = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    wire w_acc = i_in_valid && o_in_ready;
    wire w_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE) && w_free;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_kind)
                        KIND_LOAD: begin
                            o_cmd.load = 1'b1;
                            n_state = S_RDW;
                        end
                        KIND_SORT: begin
                            o_cmd.sort_start = 1'b1;
                            n_state = S_INIT;
                        end
                        KIND_READ: begin
                            o_cmd.read_req = 1'b1;
                            n_state = S_RDW;
                        end
                        default: begin
                            o_cmd.nop_item = 1'b1;
                            n_state = S_RDW;
                        end
                    endcase
                end
            end
            S_RDW: begin
                o_cmd.out_load = 1'b1;
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_INIT: begin
                if (i_stat.sort_over) begin
                    o_cmd.sort_done = 1'b1;
                    n_state = S_WAIT;
                end else if (i_stat.pass_done) begin
                    n_state = S_COPY;
                end else begin
                    o_cmd.run_init = 1'b1;
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (i_stat.run_done) begin
                    n_state = S_INIT;
                end else begin
                    o_cmd.merge_step = 1'b1;
                end
            end
            S_COPY: begin
                if (i_stat.copy_done) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.copy_step = 1'b1;
                end
            end
            S_NEXT: begin
                o_cmd.pass_next = 1'b1;
                n_state = S_INIT;
            end
            S_WAIT: begin
                if (w_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: src/ms_data.sv
// ----------------------------------------------------------------------------
// ms_data
// Store, scratch memory, merge pointers and result register.
// ----------------------------------------------------------------------------
module ms_data #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ms_pkg::t_in_item  i_item,
    input  ms_pkg::t_cmd      i_cmd,
    output ms_pkg::t_stat     o_stat,
    output ms_pkg::t_out_item o_item
);
    import ms_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1) + 1;

    logic signed [DataW-1:0] r_store   [DEPTH];
    logic signed [DataW-1:0] r_scratch [DEPTH];

    logic [CW-1:0] r_count, r_rptr, r_width, r_lo, r_mid, r_hi, r_i, r_j, r_k;
    logic          r_phase;
    logic signed [DataW-1:0] r_a, r_b, r_sd, r_rd;
    logic [1:0]    r_pend;   // merge read pipeline: 0 none, 1 awaiting data
    logic          r_cp_pend;
    logic [CW-1:0] r_cp_idx;
    logic [StatusW-1:0] r_st;
    logic          r_last;
    logic [CW-1:0] r_copy;

    wire [CW-1:0] w_lo_w  = r_lo + r_width;
    wire [CW-1:0] w_lo_2w = r_lo + (r_width << 1);
    wire [CW-1:0] w_cnt_eff = r_phase ? '0 : r_count;
    wire w_full = w_cnt_eff >= CW'(DEPTH);
    wire w_past = (r_rptr >= r_count);

    assign o_stat.sort_over = (r_width >= r_count);
    assign o_stat.pass_done = (r_lo >= r_count);
    assign o_stat.run_done  = (r_k >= r_hi) && (r_pend == 2'd0);
    assign o_stat.copy_done = (r_copy >= r_count) && !r_cp_pend;

    wire w_ia = r_i < r_mid;
    wire w_jb = r_j < r_hi;

    // load, read, sort and copy; merge fetches the head of each run into r_a/r_b, takes one, refetches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rptr  <= '0;
            r_phase <= 1'b0;
            r_pend  <= 2'd0;
            r_cp_pend <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_phase) begin
                    r_phase <= 1'b0;
                    r_rptr  <= '0;
                end
                if (!w_full) begin
                    r_store[w_cnt_eff[AW-1:0]] <= i_item.value;
                    r_count <= w_cnt_eff + 1'b1;
                end else begin
                    r_count <= w_cnt_eff;
                end
                r_st <= w_full ? ST_FULL : ST_OK;
                r_last <= 1'b0;
                r_rd <= '0;
            end
            if (i_cmd.read_req) begin
                r_phase <= 1'b1;
                r_rd <= w_past ? '0 : r_store[r_rptr[AW-1:0]];
                r_st <= w_past ? ST_PAST : ST_OK;
                r_last <= !w_past && (r_rptr + 1'b1 == r_count);
                if (!w_past) r_rptr <= r_rptr + 1'b1;
            end
            if (i_cmd.nop_item) begin
                r_st <= ST_OK;
                r_last <= 1'b0;
                r_rd <= '0;
            end
            if (i_cmd.sort_start) begin
                r_width <= CW'(1);
                r_lo <= '0;
                r_copy <= '0;
                r_st <= ST_OK;
                r_last <= 1'b0;
            end
            if (i_cmd.run_init) begin
                r_mid <= (w_lo_w < r_count) ? w_lo_w : r_count;
                r_hi  <= (w_lo_2w < r_count) ? w_lo_2w : r_count;
                r_i <= r_lo;
                r_j <= (w_lo_w < r_count) ? w_lo_w : r_count;
                r_k <= r_lo;
                r_lo <= w_lo_2w;
                r_pend <= 2'd1;
                r_a <= r_store[r_lo[AW-1:0]];
            end
            if (i_cmd.merge_step) begin
                if (r_pend == 2'd1) begin
                    // load right head
                    r_b <= r_store[r_j[AW-1:0]];
                    r_pend <= 2'd0;
                end else if (r_k < r_hi) begin
                    if (w_ia && (!w_jb || r_a <= r_b)) begin
                        r_scratch[r_k[AW-1:0]] <= r_a;
                        r_i <= r_i + 1'b1;
                        r_a <= r_store[(r_i[AW-1:0]) + AW'(1)];
                    end else begin
                        r_scratch[r_k[AW-1:0]] <= r_b;
                        r_j <= r_j + 1'b1;
                        r_b <= r_store[(r_j[AW-1:0]) + AW'(1)];
                    end
                    r_k <= r_k + 1'b1;
                end
            end
            r_cp_pend <= i_cmd.copy_step && (r_copy < r_count);
            if (i_cmd.copy_step) begin
                if (r_copy < r_count) begin
                    r_sd <= r_scratch[r_copy[AW-1:0]];
                    r_cp_idx <= r_copy;
                    r_copy <= r_copy + 1'b1;
                end
            end
            if (r_cp_pend) r_store[r_cp_idx[AW-1:0]] <= r_sd;
            if (i_cmd.pass_next) begin
                r_width <= r_width << 1;
                r_lo <= '0;
                r_copy <= '0;
            end
            if (i_cmd.sort_done) begin
                r_rptr <= '0;
                r_rd <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_item.value_res     <= r_rd;
            o_item.status        <= r_st;
            o_item.last          <= r_last;
            o_item.element_total <= TotalW'(r_count);
        end
    end

endmodule
